FILE: rtl/mcbf_pkg.sv
// Shared types and constants for the multi-channel bounded FIFO bank.
// Holds the operation and status codes, fixed field widths and the control
// record passed from the front end through the command queue to the back end.
package mcbf_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHANNEL_W = 3;
  localparam int SEND_W = 32;
  localparam int SIZE_W = 5;
  localparam int STATUS_W = 2;
  localparam int RECV_W = 32;
  localparam int OPENED_W = 3;

  typedef enum logic [OPCODE_W-1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_SEND  = 2'd2,
    OP_RECV  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_CHANNEL  = 2'd1,
    ST_WOULD_BLOCK = 2'd2,
    ST_NO_FREE     = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [OPENED_W-1:0]   opened;
    logic                  wr;
    logic                  rd;
  } ctrl_t;

endpackage

FILE: rtl/multi_channel_bounded_fifo_core.sv
// Multi-channel bounded FIFO bank, top level.
// Each input transfer carries one operation: open, close, try-send or
// try-receive. Open claims the lowest free channel with a capacity clamped
// to CHANNEL_DEPTH; send and receive use each channel as a ring in its own
// region of a shared message store. Nothing blocks: a full or empty channel
// answers would-block, and every input transfer gives exactly one result.
// The front end writes the command queue at the accepting edge, and the
// back end pops it and reads the store once the output register is free,
// so out_valid rises when that result is registered.
// Throughput: one item per cycle while out_stall is low, set by the single
// store port and the single per-channel state update in the front end.
// Reset closes every channel and empties the queue and output register;
// the message store is not cleared, since only written words are read.
// When the receiver stalls, the result holds in the output register and
// up to two more items wait in the command queue; in_stall then rises.
// Depends on mcbf_pkg, mcbf_front, mcbf_queue and mcbf_back.
module multi_channel_bounded_fifo_core #(
  parameter int NUM_CHANNELS = 8,
  parameter int CHANNEL_DEPTH = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mcbf_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [mcbf_pkg::CHANNEL_W-1:0] in_channel,
  input  logic [mcbf_pkg::SEND_W-1:0]    in_send_data,
  input  logic [mcbf_pkg::SIZE_W-1:0]    in_capacity,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mcbf_pkg::STATUS_W-1:0]  out_status,
  output logic [mcbf_pkg::RECV_W-1:0]    out_recv_data,
  output logic [mcbf_pkg::OPENED_W-1:0]  out_opened_channel
);

  localparam int ADDR_W = (NUM_CHANNELS * CHANNEL_DEPTH > 1)
                          ? $clog2(NUM_CHANNELS * CHANNEL_DEPTH) : 1;

  logic                  acc;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  mcbf_pkg::ctrl_t       f_ctrl;
  logic [ADDR_W-1:0]     f_addr;
  logic [DATA_WIDTH-1:0] f_data;
  mcbf_pkg::ctrl_t       h_ctrl;
  logic [ADDR_W-1:0]     h_addr;
  logic [DATA_WIDTH-1:0] h_data;

  assign in_stall = q_full;
  assign acc = in_valid && !q_full;

  mcbf_front #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .CHANNEL_DEPTH(CHANNEL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .ADDR_W(ADDR_W)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .acc(acc),
    .opcode(in_opcode),
    .channel(in_channel),
    .send_data(in_send_data),
    .capacity(in_capacity),
    .cmd_ctrl(f_ctrl),
    .cmd_addr(f_addr),
    .cmd_data(f_data)
  );

  mcbf_queue #(
    .ADDR_W(ADDR_W),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(acc),
    .push_ctrl(f_ctrl),
    .push_addr(f_addr),
    .push_data(f_data),
    .pop(q_pop),
    .full(q_full),
    .empty(q_empty),
    .head_ctrl(h_ctrl),
    .head_addr(h_addr),
    .head_data(h_data)
  );

  mcbf_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .CHANNEL_DEPTH(CHANNEL_DEPTH),
    .DATA_WIDTH(DATA_WIDTH),
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .q_empty(q_empty),
    .q_ctrl(h_ctrl),
    .q_addr(h_addr),
    .q_data(h_data),
    .q_pop(q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_recv_data(out_recv_data),
    .out_opened_channel(out_opened_channel)
  );

endmodule

FILE: rtl/mcbf_front.sv
// Front end of the FIFO bank: accepts items, holds the per-channel state
// and turns each item into a result record plus an optional store access.
// Depends on mcbf_pkg.
module mcbf_front #(
  parameter int NUM_CHANNELS = 8,
  parameter int CHANNEL_DEPTH = 16,
  parameter int DATA_WIDTH = 32,
  parameter int ADDR_W = 7
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic [mcbf_pkg::OPCODE_W-1:0]  opcode,
  input  logic [mcbf_pkg::CHANNEL_W-1:0] channel,
  input  logic [mcbf_pkg::SEND_W-1:0]    send_data,
  input  logic [mcbf_pkg::SIZE_W-1:0]    capacity,
  output mcbf_pkg::ctrl_t                cmd_ctrl,
  output logic [ADDR_W-1:0]              cmd_addr,
  output logic [DATA_WIDTH-1:0]          cmd_data
);

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(CHANNEL_DEPTH + 1);
  localparam int PTR_W = (CHANNEL_DEPTH > 1) ? $clog2(CHANNEL_DEPTH) : 1;

  logic [NUM_CHANNELS-1:0] open_r, open_nxt;
  logic [CNT_W-1:0]        limit_r [NUM_CHANNELS];
  logic [CNT_W-1:0]        count_r [NUM_CHANNELS];
  logic [PTR_W-1:0]        rptr_r  [NUM_CHANNELS];

  logic [CH_IDX_W-1:0] ch_sel;
  logic                ch_ok;
  logic [CH_IDX_W-1:0] free_idx;
  logic                free_found;
  logic [CNT_W-1:0]    new_limit;
  logic [CNT_W-1:0]    cur_count;
  logic [CNT_W-1:0]    cur_limit;
  logic [PTR_W-1:0]    cur_rptr;
  logic [CNT_W:0]      slot_sum;
  logic [PTR_W-1:0]    slot;
  logic [PTR_W-1:0]    rptr_inc;
  logic [ADDR_W-1:0]   base_addr;

  logic                upd_en;
  logic [CH_IDX_W-1:0] upd_idx;
  logic [CNT_W-1:0]    limit_nxt;
  logic [CNT_W-1:0]    count_nxt;
  logic [PTR_W-1:0]    rptr_nxt;

  assign ch_sel = CH_IDX_W'(channel);
  assign ch_ok = (int'(channel) < NUM_CHANNELS) && open_r[ch_sel];
  assign cur_count = count_r[ch_sel];
  assign cur_limit = limit_r[ch_sel];
  assign cur_rptr = rptr_r[ch_sel];

  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!open_r[i]) begin
        free_idx = CH_IDX_W'(i);
        free_found = 1'b1;
      end
    end
  end

  assign new_limit = (int'(capacity) < CHANNEL_DEPTH) ? CNT_W'(capacity)
                                                       : CNT_W'(CHANNEL_DEPTH);

  always_comb begin
    slot_sum = (CNT_W + 1)'(cur_rptr) + (CNT_W + 1)'(cur_count);
    if (slot_sum >= (CNT_W + 1)'(CHANNEL_DEPTH)) begin
      slot = PTR_W'(slot_sum - (CNT_W + 1)'(CHANNEL_DEPTH));
    end else begin
      slot = PTR_W'(slot_sum);
    end
  end

  assign rptr_inc = (int'(cur_rptr) == CHANNEL_DEPTH - 1) ? '0 : PTR_W'(cur_rptr + 1'b1);
  assign base_addr = ADDR_W'(ch_sel) * ADDR_W'(CHANNEL_DEPTH);

  always_comb begin
    cmd_ctrl.status = mcbf_pkg::ST_OK;
    cmd_ctrl.opened = '0;
    cmd_ctrl.wr = 1'b0;
    cmd_ctrl.rd = 1'b0;
    cmd_addr = base_addr;
    cmd_data = DATA_WIDTH'(send_data);
    open_nxt = open_r;
    upd_en = 1'b0;
    upd_idx = ch_sel;
    limit_nxt = cur_limit;
    count_nxt = cur_count;
    rptr_nxt = cur_rptr;
    if (mcbf_pkg::op_t'(opcode) == mcbf_pkg::OP_OPEN) begin
      if (free_found) begin
        open_nxt[free_idx] = 1'b1;
        upd_en = 1'b1;
        upd_idx = free_idx;
        limit_nxt = new_limit;
        count_nxt = '0;
        rptr_nxt = '0;
        cmd_ctrl.opened = mcbf_pkg::OPENED_W'(free_idx);
      end else begin
        cmd_ctrl.status = mcbf_pkg::ST_NO_FREE;
      end
    end else if (!ch_ok) begin
      cmd_ctrl.status = mcbf_pkg::ST_NO_CHANNEL;
    end else begin
      case (mcbf_pkg::op_t'(opcode))
        mcbf_pkg::OP_CLOSE: begin
          open_nxt[ch_sel] = 1'b0;
          upd_en = 1'b1;
          limit_nxt = '0;
          count_nxt = '0;
          rptr_nxt = '0;
        end
        mcbf_pkg::OP_SEND: begin
          if (cur_count >= cur_limit) begin
            cmd_ctrl.status = mcbf_pkg::ST_WOULD_BLOCK;
          end else begin
            cmd_ctrl.wr = 1'b1;
            cmd_addr = base_addr + ADDR_W'(slot);
            upd_en = 1'b1;
            count_nxt = cur_count + 1'b1;
          end
        end
        mcbf_pkg::OP_RECV: begin
          if (cur_count == '0) begin
            cmd_ctrl.status = mcbf_pkg::ST_WOULD_BLOCK;
          end else begin
            cmd_ctrl.rd = 1'b1;
            cmd_addr = base_addr + ADDR_W'(cur_rptr);
            upd_en = 1'b1;
            count_nxt = cur_count - 1'b1;
            rptr_nxt = rptr_inc;
          end
        end
        default: begin
          cmd_ctrl.status = mcbf_pkg::ST_NO_CHANNEL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        limit_r[i] <= '0;
        count_r[i] <= '0;
        rptr_r[i] <= '0;
      end
    end else if (acc) begin
      open_r <= open_nxt;
      if (upd_en) begin
        limit_r[upd_idx] <= limit_nxt;
        count_r[upd_idx] <= count_nxt;
        rptr_r[upd_idx] <= rptr_nxt;
      end
    end
  end

endmodule

FILE: rtl/mcbf_queue.sv
// Two-entry command queue between the front end and the back end.
// Carries the result record, store address and write data of each item.
// Depends on mcbf_pkg.
module mcbf_queue #(
  parameter int ADDR_W = 7,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mcbf_pkg::ctrl_t       push_ctrl,
  input  logic [ADDR_W-1:0]     push_addr,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic                  pop,
  output logic                  full,
  output logic                  empty,
  output mcbf_pkg::ctrl_t       head_ctrl,
  output logic [ADDR_W-1:0]     head_addr,
  output logic [DATA_WIDTH-1:0] head_data
);

  mcbf_pkg::ctrl_t       ctrl_r [2];
  logic [ADDR_W-1:0]     addr_r [2];
  logic [DATA_WIDTH-1:0] data_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            fill_r;

  assign full = (fill_r == 2'd2);
  assign empty = (fill_r == 2'd0);
  assign head_ctrl = ctrl_r[rd_ptr_r];
  assign head_addr = addr_r[rd_ptr_r];
  assign head_data = data_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctrl_r[wr_ptr_r] <= push_ctrl;
      addr_r[wr_ptr_r] <= push_addr;
      data_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/mcbf_back.sv
// Back end of the FIFO bank: owns the message store, performs the write or
// read of each queued command and holds the result in the output register.
// Depends on mcbf_pkg.
module mcbf_back #(
  parameter int NUM_CHANNELS = 8,
  parameter int CHANNEL_DEPTH = 16,
  parameter int DATA_WIDTH = 32,
  parameter int ADDR_W = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  input  mcbf_pkg::ctrl_t               q_ctrl,
  input  logic [ADDR_W-1:0]             q_addr,
  input  logic [DATA_WIDTH-1:0]         q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mcbf_pkg::STATUS_W-1:0] out_status,
  output logic [mcbf_pkg::RECV_W-1:0]   out_recv_data,
  output logic [mcbf_pkg::OPENED_W-1:0] out_opened_channel
);

  localparam int STORE_WORDS = NUM_CHANNELS * CHANNEL_DEPTH;

  logic [DATA_WIDTH-1:0] mem_r [STORE_WORDS];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  valid_r;
  mcbf_pkg::ctrl_t       ctrl_r;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (q_pop && q_ctrl.wr) begin
      mem_r[q_addr] <= q_data;
    end
    if (q_pop && q_ctrl.rd) begin
      rdata_r <= mem_r[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ctrl_r <= q_ctrl;
    end
  end

  assign out_valid = valid_r;
  assign out_status = ctrl_r.status;
  assign out_opened_channel = ctrl_r.opened;
  assign out_recv_data = ctrl_r.rd ? mcbf_pkg::RECV_W'(rdata_r) : '0;

endmodule

FILE: tb/testbench.sv
// Testbench for multi_channel_bounded_fifo_core: drives open, close, send and receive
// requests with random idling and back-pressure, and checks every result in order.
// Depends on mcbf_pkg and the block under test; a scoreboard class predicts each result.
`timescale 1ns / 1ps

localparam int BANK_CHANNELS = 8;
localparam int BANK_DEPTH = 16;
localparam int PTR_W = $clog2(BANK_DEPTH);

typedef struct packed {
  mcbf_pkg::op_t                  op;
  logic [mcbf_pkg::CHANNEL_W-1:0] chan;
  logic [mcbf_pkg::SEND_W-1:0]    data;
  logic [mcbf_pkg::SIZE_W-1:0]    size;
} bank_request_t;

typedef struct packed {
  mcbf_pkg::status_t             status;
  logic [mcbf_pkg::RECV_W-1:0]   recv;
  logic [mcbf_pkg::OPENED_W-1:0] opened;
} bank_response_t;

class channel_bank_scoreboard;
  bit                        is_open[BANK_CHANNELS];
  bit [mcbf_pkg::SIZE_W-1:0] limit[BANK_CHANNELS];
  bit [mcbf_pkg::SIZE_W-1:0] fill[BANK_CHANNELS];
  bit [PTR_W-1:0]            head[BANK_CHANNELS];
  bit [mcbf_pkg::RECV_W-1:0] words[BANK_CHANNELS][BANK_DEPTH];
  bank_response_t            pending_responses[$];
  int unsigned               mismatches;

  function void note_request(bank_request_t req);
    bank_response_t resp;
    int slot;
    int ch;
    resp.status = mcbf_pkg::ST_OK;
    resp.recv = '0;
    resp.opened = '0;
    ch = int'(req.chan);
    if (req.op == mcbf_pkg::OP_OPEN) begin
      resp.status = mcbf_pkg::ST_NO_FREE;
      for (int i = 0; i < BANK_CHANNELS; i++) begin
        if (!is_open[i] && resp.status == mcbf_pkg::ST_NO_FREE) begin
          is_open[i] = 1'b1;
          limit[i] = (int'(req.size) < BANK_DEPTH) ? req.size
                                                   : mcbf_pkg::SIZE_W'(BANK_DEPTH);
          fill[i] = '0;
          head[i] = '0;
          resp.status = mcbf_pkg::ST_OK;
          resp.opened = mcbf_pkg::OPENED_W'(i);
        end
      end
    end else if (ch >= BANK_CHANNELS || !is_open[ch]) begin
      resp.status = mcbf_pkg::ST_NO_CHANNEL;
    end else if (req.op == mcbf_pkg::OP_CLOSE) begin
      is_open[ch] = 1'b0;
      limit[ch] = '0;
      fill[ch] = '0;
      head[ch] = '0;
    end else if (req.op == mcbf_pkg::OP_SEND) begin
      if (fill[ch] >= limit[ch]) begin
        resp.status = mcbf_pkg::ST_WOULD_BLOCK;
      end else begin
        slot = (int'(head[ch]) + int'(fill[ch])) % BANK_DEPTH;
        words[ch][slot] = req.data;
        fill[ch] = fill[ch] + 1'b1;
      end
    end else begin
      if (fill[ch] == 0) begin
        resp.status = mcbf_pkg::ST_WOULD_BLOCK;
      end else begin
        resp.recv = words[ch][head[ch]];
        head[ch] = PTR_W'((int'(head[ch]) + 1) % BANK_DEPTH);
        fill[ch] = fill[ch] - 1'b1;
      end
    end
    pending_responses.push_back(resp);
  endfunction

  task report(string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  task check_response(logic [mcbf_pkg::STATUS_W-1:0] status,
                      logic [mcbf_pkg::RECV_W-1:0] recv,
                      logic [mcbf_pkg::OPENED_W-1:0] opened);
    bank_response_t    want;
    mcbf_pkg::status_t got;
    got = mcbf_pkg::status_t'(status);
    if (pending_responses.size() == 0) begin
      report($sformatf("unexpected result status %0d recv %h", status, recv));
    end else begin
      want = pending_responses.pop_front();
      if (got != want.status)
        report($sformatf("status %s, expected %s", got.name(), want.status.name()));
      if (recv != want.recv)
        report($sformatf("recv_data %h, expected %h", recv, want.recv));
      if (opened != want.opened)
        report($sformatf("opened_channel %0d, expected %0d", opened, want.opened));
    end
  endtask
endclass

module testbench;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam int PHASES = 13;
  localparam int PHASE_ITEMS = 100;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [mcbf_pkg::OPCODE_W-1:0]  in_opcode = '0;
  logic [mcbf_pkg::CHANNEL_W-1:0] in_channel = '0;
  logic [mcbf_pkg::SEND_W-1:0]    in_send_data = '0;
  logic [mcbf_pkg::SIZE_W-1:0]    in_capacity = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [mcbf_pkg::STATUS_W-1:0]  out_status;
  logic [mcbf_pkg::RECV_W-1:0]    out_recv_data;
  logic [mcbf_pkg::OPENED_W-1:0]  out_opened_channel;

  channel_bank_scoreboard bank;
  bit                     no_idle = 1'b0;
  bit                     hold_off_request = 1'b0;
  int unsigned            cycle_count = 0;

  multi_channel_bounded_fifo_core #(
    .NUM_CHANNELS(BANK_CHANNELS),
    .CHANNEL_DEPTH(BANK_DEPTH),
    .DATA_WIDTH(mcbf_pkg::SEND_W)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_channel(in_channel),
    .in_send_data(in_send_data),
    .in_capacity(in_capacity),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_recv_data(out_recv_data),
    .out_opened_channel(out_opened_channel)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_channel_bounded_fifo_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      bank.check_response(out_status, out_recv_data, out_opened_channel);
  end

  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 45);
  endfunction

  function automatic bank_request_t make_request(mcbf_pkg::op_t op, int chan,
                                                 logic [mcbf_pkg::SEND_W-1:0] data,
                                                 int size);
    bank_request_t req;
    req.op = op;
    req.chan = mcbf_pkg::CHANNEL_W'(chan);
    req.data = data;
    req.size = mcbf_pkg::SIZE_W'(size);
    return req;
  endfunction

  function automatic bank_request_t random_request(int unsigned mix);
    bank_request_t req;
    int unsigned r, live, pick, open_pct, close_pct, send_pct;
    live = 0;
    for (int i = 0; i < BANK_CHANNELS; i++) if (bank.is_open[i]) live++;
    case (mix)
      0: begin open_pct = 8;  close_pct = 5;  send_pct = 45; end
      1: begin open_pct = 5;  close_pct = 3;  send_pct = 70; end
      2: begin open_pct = 5;  close_pct = 3;  send_pct = 22; end
      default: begin open_pct = 25; close_pct = 25; send_pct = 25; end
    endcase
    if (live < 2) open_pct += 30;
    r = $urandom_range(0, 99);
    if (r < open_pct) req.op = mcbf_pkg::OP_OPEN;
    else if (r < open_pct + close_pct) req.op = mcbf_pkg::OP_CLOSE;
    else if (r < open_pct + close_pct + send_pct) req.op = mcbf_pkg::OP_SEND;
    else req.op = mcbf_pkg::OP_RECV;
    req.chan = mcbf_pkg::CHANNEL_W'($urandom_range(0, BANK_CHANNELS - 1));
    if (live > 0 && $urandom_range(0, 99) < 85) begin
      pick = $urandom_range(0, live - 1);
      for (int i = 0; i < BANK_CHANNELS; i++) begin
        if (bank.is_open[i]) begin
          if (pick == 0) req.chan = mcbf_pkg::CHANNEL_W'(i);
          pick--;
        end
      end
    end
    req.data = $urandom;
    r = $urandom_range(0, 99);
    if (r < 8) req.size = mcbf_pkg::SIZE_W'($urandom_range(17, 31));
    else if (r < 15) req.size = '0;
    else if (r < 40) req.size = mcbf_pkg::SIZE_W'($urandom_range(1, 4));
    else req.size = mcbf_pkg::SIZE_W'($urandom_range(1, BANK_DEPTH));
    return req;
  endfunction

  task automatic offer(bank_request_t req);
    int unsigned gap;
    in_valid <= 1'b1;
    in_opcode <= req.op;
    in_channel <= req.chan;
    in_send_data <= req.data;
    in_capacity <= req.size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bank.note_request(req);
    gap = no_idle ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : receiver
    @(posedge clk);
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (!no_idle) begin
        int unsigned len;
        len = idle_length();
        if (len > 0) begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : stimulus
    bank = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer(make_request(mcbf_pkg::OP_RECV, 0, '0, 0));
    offer(make_request(mcbf_pkg::OP_CLOSE, 7, '0, 0));
    offer(make_request(mcbf_pkg::OP_SEND, 3, 32'h1234_5678, 0));
    offer(make_request(mcbf_pkg::OP_OPEN, 5, '0, 0));
    offer(make_request(mcbf_pkg::OP_SEND, 0, 32'hDEAD_BEEF, 0));
    offer(make_request(mcbf_pkg::OP_RECV, 0, '0, 0));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 31));
    offer(make_request(mcbf_pkg::OP_OPEN, 7, '0, 16));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 1));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 17));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 2));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 3));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 4));
    offer(make_request(mcbf_pkg::OP_OPEN, 0, '0, 8));
    offer(make_request(mcbf_pkg::OP_SEND, 3, 32'hFFFF_FFFF, 0));
    offer(make_request(mcbf_pkg::OP_SEND, 3, 32'h0000_0000, 0));
    offer(make_request(mcbf_pkg::OP_RECV, 3, '0, 0));
    offer(make_request(mcbf_pkg::OP_RECV, 3, '0, 0));
    offer(make_request(mcbf_pkg::OP_CLOSE, 5, '0, 0));
    offer(make_request(mcbf_pkg::OP_OPEN, 2, '0, 31));
    offer(make_request(mcbf_pkg::OP_CLOSE, 0, '0, 0));
    offer(make_request(mcbf_pkg::OP_CLOSE, 0, '0, 0));
    offer(make_request(mcbf_pkg::OP_SEND, 1, 32'hA5A5_5A5A, 0));
    offer(make_request(mcbf_pkg::OP_RECV, 1, '0, 0));

    for (int phase = 0; phase < PHASES; phase++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase % 5 == 1) hold_off_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer(random_request((phase % 5 == 1) ? 1 : $urandom_range(0, 3)));
    end
    no_idle = 1'b0;

    in_valid <= 1'b0;
    while (bank.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bank.mismatches == 0)
      $display("multi_channel_bounded_fifo_core verification clean");
    else
      $display("multi_channel_bounded_fifo_core verification failed");
    $finish;
  end
endmodule
